/* rtl/mtl_pkg.sv */
// Package for the microtime linearizer: field widths, codes and the
// pipeline sideband type. Used by the interpolation, modulo and top-level files.
package mtl_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int TABLE_DEPTH_DEF  = 4096;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 13;

  typedef enum logic [1:0] {
    OP_PHOTON = 2'd0,
    OP_ENTRY  = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_FLAG   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PATH_TABLE    = 2'd0,
    PATH_INVALID  = 2'd1,
    PATH_NO_TABLE = 2'd2,
    PATH_RANGE    = 2'd3
  } path_e;

  localparam logic [CFG_IDX_W-1:0] REG_DITHER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd1;

  typedef struct packed {
    logic               valid;
    logic [7:0]         ch;
    logic [15:0]        mt;
    path_e              path;
    logic               last;
    logic signed [16:0] sh;
    logic               do_wrap;
  } meta_t;

endpackage

/* rtl/mtl_if.sv */
// Stream interfaces of the microtime linearizer: photon/command words in,
// result words out, and the configuration write channel.
interface mtl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [7:0]         channel;
  logic [15:0]        microtime;
  logic [15:0]        dither_fraction;
  logic [11:0]        table_index;
  logic [23:0]        table_value;
  logic signed [16:0] shift_value;
  logic               table_enable;
  logic               last_photon;
  modport source (output valid, opcode, channel, microtime, dither_fraction, table_index,
                  table_value, shift_value, table_enable, last_photon, input ready);
  modport sink (input valid, opcode, channel, microtime, dither_fraction, table_index,
                table_value, shift_value, table_enable, last_photon, output ready);
endinterface

interface mtl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] corrected_time;
  logic [7:0]  photon_channel;
  logic [1:0]  path_taken;
  logic        batch_end;
  modport source (output valid, corrected_time, photon_channel, path_taken, batch_end,
                  input ready);
  modport sink (input valid, corrected_time, photon_channel, path_taken, batch_end,
                output ready);
endinterface

interface mtl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/mtl_bank.sv */
// One bank of the correction table memory with a registered read port.
// Standalone; no package dependency.
module mtl_bank #(
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [23:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [23:0]   rdata_o
);
  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/mtl_interp.sv */
// Two-stage interpolation and rounding of neighboring table entries.
// Depends on mtl_pkg for the sideband type.
module mtl_interp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [23:0]   a_i,
  input  logic [23:0]   b_i,
  input  logic [15:0]   r_i,
  input  mtl_pkg::meta_t meta_i,
  output logic [16:0]   v_o,
  output mtl_pkg::meta_t meta_o
);
  import mtl_pkg::*;

  logic [40:0] p0_q, p1_q;
  logic [16:0] v_q;
  meta_t       m2_q, m3_q;
  logic [40:0] t_w;

  assign t_w = p0_q + p1_q + 41'(1 << 23);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= 41'(a_i * (17'h10000 - {1'b0, r_i}));
      p1_q <= 41'(b_i * r_i);
      v_q  <= t_w[40:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_q <= '0;
      m3_q <= '0;
    end else if (en_i) begin
      m2_q <= meta_i;
      m3_q <= m2_q;
    end
  end

  assign v_o    = v_q;
  assign meta_o = m3_q;
endmodule

/* rtl/mtl_modulo.sv */
// Four-stage restoring reduction of the saturated time modulo table_size.
// Depends on mtl_pkg for the sideband type.
module mtl_modulo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [12:0]    size_i,
  input  logic [15:0]    x_i,
  input  mtl_pkg::meta_t meta_i,
  output logic [15:0]    rem_o,
  output mtl_pkg::meta_t meta_o
);
  import mtl_pkg::*;

  localparam int NSTG = 4;
  localparam int NSTP = 4;

  logic [15:0] rem_q [NSTG];
  meta_t       meta_q [NSTG];
  logic [15:0] rem_in [NSTG];
  meta_t       meta_in [NSTG];
  logic [15:0] rem_d [NSTG];

  always_comb begin
    logic [28:0] r;
    logic [28:0] d;
    for (int s = 0; s < NSTG; s++) begin
      rem_in[s]  = (s == 0) ? x_i : rem_q[(s == 0) ? 0 : s - 1];
      meta_in[s] = (s == 0) ? meta_i : meta_q[(s == 0) ? 0 : s - 1];
      r = {13'b0, rem_in[s]};
      for (int j = 0; j < NSTP; j++) begin
        d = {16'b0, size_i} << (15 - NSTP * s - j);
        if (meta_in[s].do_wrap && r >= d) begin
          r = r - d;
        end
      end
      rem_d[s] = r[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NSTG; s++) begin
        rem_q[s] <= rem_d[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTG; s++) begin
        meta_q[s] <= '0;
      end
    end else if (en_i) begin
      for (int s = 0; s < NSTG; s++) begin
        meta_q[s] <= meta_in[s];
      end
    end
  end

  assign rem_o  = rem_q[NSTG-1];
  assign meta_o = meta_q[NSTG-1];
endmodule

/* rtl/microtime_lut_linearizer.sv */
// Microtime linearizer top level: input register, table lookup, interpolation,
// shift and wrap, and modulo reduction. Uses mtl_pkg, mtl_if and all submodules.
// A result passes the input, table read, interpolation, shift and modulo registers.
// Throughput: one word per cycle; the whole pipeline stalls only when the result waits.
// Reset clears shifts, present flags, configuration registers and valid bits; table memory is
// undefined until written and needs no clearing pass.
module microtime_lut_linearizer #(
  parameter int NUM_CHANNELS = mtl_pkg::NUM_CHANNELS_DEF,
  parameter int TABLE_DEPTH  = mtl_pkg::TABLE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtl_in_if.sink    photon_i,
  mtl_out_if.source result_o,
  mtl_cfg_if.sink   cfg_i
);
  import mtl_pkg::*;

  localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HD    = (TABLE_DEPTH + 1) / 2;
  localparam int BD    = NUM_CHANNELS * HD;
  localparam int AW    = (BD > 1) ? $clog2(BD) : 1;
  localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);

  logic               en;
  logic               dither_q;
  logic [12:0]        size_q;

  logic               s0_valid_q;
  logic [1:0]         s0_op_q;
  logic [7:0]         s0_ch_q;
  logic [15:0]        s0_mt_q, s0_r_q;
  logic [11:0]        s0_idx_q;
  logic [23:0]        s0_val_q;
  logic signed [16:0] s0_shv_q;
  logic               s0_en_q, s0_last_q;

  logic signed [16:0] shift_q [NUM_CHANNELS];
  logic               present_q [NUM_CHANNELS];

  logic               ch_ok, present, range_bad, do_wrap;
  logic [CW-1:0]      chi;
  logic signed [16:0] sh;
  logic [16:0]        lim, mt_p1;
  path_e              path;
  logic [31:0]        base_w, waddr_w, eaddr_w, oaddr_w;
  logic               we_e, we_o, re;
  logic [23:0]        rd_e, rd_o;

  meta_t              s1_q, s3_meta, s4_q, out_meta;
  logic               s1_sel_q;
  logic [15:0]        s1_r_q;
  logic [16:0]        v;
  logic [15:0]        s4_x_q, rem;

  assign en = !result_o.valid || result_o.ready;
  assign photon_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_q <= 1'b0;
      size_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DITHER: dither_q <= cfg_i.data[0];
        REG_SIZE:   size_q   <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= photon_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_op_q   <= photon_i.opcode;
      s0_ch_q   <= photon_i.channel;
      s0_mt_q   <= photon_i.microtime;
      s0_r_q    <= photon_i.dither_fraction;
      s0_idx_q  <= photon_i.table_index;
      s0_val_q  <= photon_i.table_value;
      s0_shv_q  <= photon_i.shift_value;
      s0_en_q   <= photon_i.table_enable;
      s0_last_q <= photon_i.last_photon;
    end
  end

  assign ch_ok   = {1'b0, s0_ch_q} < 9'(NUM_CHANNELS);
  assign chi     = s0_ch_q[CW-1:0];
  assign present = ch_ok && present_q[chi];
  assign sh      = ch_ok ? shift_q[chi] : 17'sd0;
  assign lim     = ({4'b0, size_q} < DEPTH_L) ? {4'b0, size_q} : DEPTH_L;
  assign mt_p1   = {1'b0, s0_mt_q} + 17'd1;
  assign range_bad = (size_q == '0) || (mt_p1 >= lim);

  always_comb begin
    if (!ch_ok) begin
      path = PATH_INVALID;
    end else if (!present) begin
      path = PATH_NO_TABLE;
    end else if (range_bad) begin
      path = PATH_RANGE;
    end else begin
      path = PATH_TABLE;
    end
  end

  assign do_wrap = (path == PATH_TABLE) ||
                   ((path == PATH_RANGE) && (sh != 17'sd0) && (size_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        shift_q[i]   <= '0;
        present_q[i] <= 1'b0;
      end
    end else if (en && s0_valid_q && ch_ok) begin
      case (op_e'(s0_op_q))
        OP_SHIFT: shift_q[chi]   <= s0_shv_q;
        OP_FLAG:  present_q[chi] <= s0_en_q;
        default:  ;
      endcase
    end
  end

  assign base_w  = 32'(s0_ch_q) * 32'(HD);
  assign waddr_w = base_w + 32'(s0_idx_q[11:1]);
  assign eaddr_w = base_w + 32'(s0_mt_q[0] ? mt_p1[16:1] : {1'b0, s0_mt_q[15:1]});
  assign oaddr_w = base_w + 32'(s0_mt_q[15:1]);
  assign we_e = en && s0_valid_q && (op_e'(s0_op_q) == OP_ENTRY) && ch_ok &&
                (32'(s0_idx_q) < 32'(TABLE_DEPTH)) && !s0_idx_q[0];
  assign we_o = en && s0_valid_q && (op_e'(s0_op_q) == OP_ENTRY) && ch_ok &&
                (32'(s0_idx_q) < 32'(TABLE_DEPTH)) && s0_idx_q[0];
  assign re   = en && s0_valid_q && (op_e'(s0_op_q) == OP_PHOTON) && (path == PATH_TABLE);

  mtl_bank #(.DEPTH(BD), .AW(AW)) u_bank_even (
    .clk_i, .we_i(we_e), .waddr_i(waddr_w[AW-1:0]), .wdata_i(s0_val_q),
    .re_i(re), .raddr_i(eaddr_w[AW-1:0]), .rdata_o(rd_e)
  );

  mtl_bank #(.DEPTH(BD), .AW(AW)) u_bank_odd (
    .clk_i, .we_i(we_o), .waddr_i(waddr_w[AW-1:0]), .wdata_i(s0_val_q),
    .re_i(re), .raddr_i(oaddr_w[AW-1:0]), .rdata_o(rd_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en) begin
      s1_q.valid   <= s0_valid_q && (op_e'(s0_op_q) == OP_PHOTON);
      s1_q.ch      <= s0_ch_q;
      s1_q.mt      <= s0_mt_q;
      s1_q.path    <= path;
      s1_q.last    <= s0_last_q;
      s1_q.sh      <= sh;
      s1_q.do_wrap <= do_wrap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sel_q <= s0_mt_q[0];
      s1_r_q   <= dither_q ? s0_r_q : 16'd0;
    end
  end

  mtl_interp u_interp (
    .clk_i, .rst_ni, .en_i(en),
    .a_i(s1_sel_q ? rd_o : rd_e), .b_i(s1_sel_q ? rd_e : rd_o),
    .r_i(s1_r_q), .meta_i(s1_q), .v_o(v), .meta_o(s3_meta)
  );

  logic [16:0]        v_sel;
  logic signed [18:0] x1, x2;
  logic [15:0]        x_sat;

  always_comb begin
    v_sel = (s3_meta.path == PATH_TABLE) ? v : {1'b0, s3_meta.mt};
    x1 = $signed({2'b0, v_sel}) + 19'(s3_meta.sh);
    x2 = (s3_meta.do_wrap && x1 < 0) ? x1 + $signed({6'b0, size_q}) : x1;
    if (x2 < 0) begin
      x_sat = 16'd0;
    end else if (x2 > 19'sd65535) begin
      x_sat = 16'hFFFF;
    end else begin
      x_sat = x2[15:0];
    end
    if ((s3_meta.path == PATH_INVALID) ||
        ((s3_meta.path == PATH_RANGE) && !s3_meta.do_wrap)) begin
      x_sat = s3_meta.mt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (en) begin
      s4_q <= s3_meta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_x_q <= x_sat;
    end
  end

  mtl_modulo u_modulo (
    .clk_i, .rst_ni, .en_i(en), .size_i(size_q), .x_i(s4_x_q), .meta_i(s4_q),
    .rem_o(rem), .meta_o(out_meta)
  );

  assign result_o.valid          = out_meta.valid;
  assign result_o.corrected_time = rem;
  assign result_o.photon_channel = out_meta.ch;
  assign result_o.path_taken     = out_meta.path;
  assign result_o.batch_end      = out_meta.last;
endmodule
